[rtl/core/tournament_branch_predictor_macros.svh]
`ifndef TOURNAMENT_BRANCH_PREDICTOR_MACROS_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define TBP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define TBP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/tbp_pkg.sv]
package tbp_pkg;

    localparam int BIMODAL_ENTRIES = 2048;
    localparam int GLOBAL_ENTRIES  = 2048;
    localparam int CHOOSER_ENTRIES = 2048;
    localparam int HISTORY_WIDTH   = 11;

    localparam int BIM_IW = $clog2(BIMODAL_ENTRIES);
    localparam int GLB_IW = $clog2(GLOBAL_ENTRIES);
    localparam int CHO_IW = $clog2(CHOOSER_ENTRIES);

    localparam int CLR_ENTRIES_BG = (BIMODAL_ENTRIES > GLOBAL_ENTRIES) ?
                                    BIMODAL_ENTRIES : GLOBAL_ENTRIES;
    localparam int CLR_ENTRIES    = (CLR_ENTRIES_BG > CHOOSER_ENTRIES) ?
                                    CLR_ENTRIES_BG : CHOOSER_ENTRIES;
    localparam int CLR_IW         = $clog2(CLR_ENTRIES);

    localparam int ADDR_W  = 32;
    localparam int TALLY_W = 32;
    localparam int CFG_W   = 4;
    localparam int CTR_W   = 2;

    localparam logic [CFG_W-1:0] HIST_BITS_RESET = 4'd11;

    typedef logic [CTR_W-1:0]         t_ctr;
    typedef logic [HISTORY_WIDTH-1:0] t_hist;

    localparam t_ctr CTR_MAX = 2'd3;
    localparam t_ctr CTR_MIN = 2'd0;

    typedef struct packed {
        logic [ADDR_W-1:0] branch_address;
        logic              taken;
    } t_tbp_in;

    typedef struct packed {
        logic               predicted_taken;
        logic               prediction_correct;
        logic               used_global;
        logic [TALLY_W-1:0] correct_count;
    } t_tbp_out;

    typedef struct packed {
        logic [BIM_IW-1:0] bim_idx;
        logic [GLB_IW-1:0] glb_idx;
        logic [CHO_IW-1:0] cho_idx;
        logic              taken;
    } t_s1;

    typedef struct packed {
        t_ctr bim;
        t_ctr glb;
        t_ctr cho;
    } t_ctr_set;

    typedef struct packed {
        logic              bim_vld;
        logic [BIM_IW-1:0] bim_idx;
        t_ctr              bim_ctr;
        logic              glb_vld;
        logic [GLB_IW-1:0] glb_idx;
        t_ctr              glb_ctr;
        logic              cho_vld;
        logic [CHO_IW-1:0] cho_idx;
        t_ctr              cho_ctr;
    } t_byp;

    typedef struct packed {
        t_ctr               bim_ctr;
        t_ctr               glb_ctr;
        t_ctr               cho_ctr;
        logic               cho_we;
        logic               pred;
        logic               ok;
        logic               use_g;
        logic [TALLY_W-1:0] tally;
    } t_res;

    typedef struct packed {
        logic              active;
        logic [CLR_IW-1:0] idx;
    } t_clr;

    function automatic t_ctr ctr_train(t_ctr c, logic up);
        t_ctr r;
        if (up) begin
            r = (c == CTR_MAX) ? c : c + t_ctr'(1);
        end else begin
            r = (c == CTR_MIN) ? c : c - t_ctr'(1);
        end
        return r;
    endfunction

endpackage

[rtl/core/tbp_ram.sv]
module tbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

[rtl/core/tbp_clear.sv]
module tbp_clear
    import tbp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    output t_clr o_clr
);

    logic              r_active;
    logic              n_active;
    logic [CLR_IW-1:0] r_idx;
    logic [CLR_IW-1:0] n_idx;

    always_comb begin
        n_active = r_active;
        n_idx    = r_idx;
        if (r_active) begin
            n_idx = r_idx + CLR_IW'(1);
            if (r_idx == CLR_IW'(CLR_ENTRIES - 1)) begin
                n_active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b1;
            r_idx    <= '0;
        end else begin
            r_active <= n_active;
            r_idx    <= n_idx;
        end
    end

    assign o_clr.active = r_active;
    assign o_clr.idx    = r_idx;

endmodule

[rtl/core/tbp_predict.sv]
module tbp_predict
    import tbp_pkg::*;
(
    input  t_s1                i_s1,
    input  t_ctr_set           i_q,
    input  t_byp               i_byp,
    input  logic [TALLY_W-1:0] i_tally,
    output t_res               o_res
);

    t_ctr bim;
    t_ctr glb;
    t_ctr cho;
    logic pb;
    logic pg;

    always_comb begin
        bim = (i_byp.bim_vld && i_byp.bim_idx == i_s1.bim_idx) ? i_byp.bim_ctr : i_q.bim;
        glb = (i_byp.glb_vld && i_byp.glb_idx == i_s1.glb_idx) ? i_byp.glb_ctr : i_q.glb;
        cho = (i_byp.cho_vld && i_byp.cho_idx == i_s1.cho_idx) ? i_byp.cho_ctr : i_q.cho;

        pb = bim[CTR_W-1];
        pg = glb[CTR_W-1];

        o_res.use_g   = cho[CTR_W-1];
        o_res.pred    = o_res.use_g ? pg : pb;
        o_res.ok      = (o_res.pred == i_s1.taken);
        o_res.bim_ctr = ctr_train(bim, i_s1.taken);
        o_res.glb_ctr = ctr_train(glb, i_s1.taken);
        o_res.cho_we  = (pb != pg);
        o_res.cho_ctr = ctr_train(cho, pg == i_s1.taken);
        o_res.tally   = (o_res.ok && i_tally != '1) ? i_tally + TALLY_W'(1) : i_tally;
    end

endmodule

[rtl/core/tournament_branch_predictor.sv]
// Tournament branch predictor: bimodal and gshare counter tables with a chooser.
// Input channel (i_valid / o_stall / i_data) carries one resolved branch per
// transaction: its address and its actual outcome. Output channel (o_valid /
// i_stall / o_data) returns one transaction per branch: the prediction used,
// whether it was correct, which side supplied it, and the running tally.
// i_cfg_we / i_cfg_wdata write the history length; write only while idle.
// A result is registered in the compute stage, then in the output register.
// Throughput: one branch per cycle unless the clearing pass or i_stall holds it,
// set by the read-modify-write of the three counter RAMs, with a one-entry write
// bypass per table covering a read that meets the previous branch's write.
// Reset: a clearing pass writes every counter to strongly taken, one entry per
// cycle over 2048 entries; o_stall stays high until it ends. History and tally
// clear at once, history length returns to 11.
// When the receiver stalls, the finished result holds in the output register,
// one more branch may wait in the compute stage, then o_stall rises.
`include "tournament_branch_predictor_macros.svh"

module tournament_branch_predictor
    import tbp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_tbp_in          i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output t_tbp_out         o_data,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    t_clr               r_clr;
    logic [CFG_W-1:0]   r_history_bits;
    t_hist              r_history;
    t_hist              n_history;
    logic [TALLY_W-1:0] r_tally;
    logic               r_s1_vld;
    t_s1                r_s1;
    t_s1                n_s1;
    t_byp               r_byp;
    t_byp               n_byp;
    logic               r_out_vld;
    t_tbp_out           r_out;
    t_ctr_set           q;
    t_res               res;
    t_hist              hist_mask;
    logic [ADDR_W-1:0]  g_full;
    logic               s1_adv;
    logic               accept;

    tbp_clear u_clear (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_clr   (r_clr)
    );

    assign s1_adv  = r_s1_vld && (!r_out_vld || !i_stall);
    assign o_stall = r_clr.active || (r_s1_vld && !s1_adv);
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_history = s1_adv ? t_hist'({r_history, r_s1.taken}) : r_history;
        for (int i = 0; i < HISTORY_WIDTH; i++) begin
            hist_mask[i] = (CFG_W'(i) < r_history_bits);
        end
        g_full        = i_data.branch_address ^ ADDR_W'(n_history & hist_mask);
        n_s1.bim_idx  = i_data.branch_address[BIM_IW-1:0];
        n_s1.glb_idx  = g_full[GLB_IW-1:0];
        n_s1.cho_idx  = i_data.branch_address[CHO_IW-1:0];
        n_s1.taken    = i_data.taken;
    end

    tbp_ram #(.WIDTH(CTR_W), .DEPTH(BIMODAL_ENTRIES)) u_bim_ram (
        .i_clk   (i_clk),
        .i_we    (r_clr.active || s1_adv),
        .i_waddr (r_clr.active ? r_clr.idx[BIM_IW-1:0] : r_s1.bim_idx),
        .i_wdata (r_clr.active ? CTR_MAX : res.bim_ctr),
        .i_re    (accept),
        .i_raddr (n_s1.bim_idx),
        .o_rdata (q.bim)
    );

    tbp_ram #(.WIDTH(CTR_W), .DEPTH(GLOBAL_ENTRIES)) u_glb_ram (
        .i_clk   (i_clk),
        .i_we    (r_clr.active || s1_adv),
        .i_waddr (r_clr.active ? r_clr.idx[GLB_IW-1:0] : r_s1.glb_idx),
        .i_wdata (r_clr.active ? CTR_MAX : res.glb_ctr),
        .i_re    (accept),
        .i_raddr (n_s1.glb_idx),
        .o_rdata (q.glb)
    );

    tbp_ram #(.WIDTH(CTR_W), .DEPTH(CHOOSER_ENTRIES)) u_cho_ram (
        .i_clk   (i_clk),
        .i_we    (r_clr.active || (s1_adv && res.cho_we)),
        .i_waddr (r_clr.active ? r_clr.idx[CHO_IW-1:0] : r_s1.cho_idx),
        .i_wdata (r_clr.active ? CTR_MAX : res.cho_ctr),
        .i_re    (accept),
        .i_raddr (n_s1.cho_idx),
        .o_rdata (q.cho)
    );

    tbp_predict u_predict (
        .i_s1    (r_s1),
        .i_q     (q),
        .i_byp   (r_byp),
        .i_tally (r_tally),
        .o_res   (res)
    );

    always_comb begin
        n_byp         = r_byp;
        if (s1_adv) begin
            n_byp.bim_vld = 1'b1;
            n_byp.bim_idx = r_s1.bim_idx;
            n_byp.bim_ctr = res.bim_ctr;
            n_byp.glb_vld = 1'b1;
            n_byp.glb_idx = r_s1.glb_idx;
            n_byp.glb_ctr = res.glb_ctr;
            n_byp.cho_vld = res.cho_we;
            n_byp.cho_idx = r_s1.cho_idx;
            n_byp.cho_ctr = res.cho_ctr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_history_bits <= HIST_BITS_RESET;
            r_history      <= '0;
            r_tally        <= '0;
            r_s1_vld       <= 1'b0;
            r_byp          <= '0;
            r_out_vld      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_history_bits <= i_cfg_wdata;
            end
            r_history <= n_history;
            r_byp     <= n_byp;
            if (s1_adv) begin
                r_tally <= res.tally;
            end
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
        if (s1_adv) begin
            r_out.predicted_taken    <= res.pred;
            r_out.prediction_correct <= res.ok;
            r_out.used_global        <= res.use_g;
            r_out.correct_count      <= res.tally;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    `TBP_ASSERT_SAME(a_clr_blocks, r_clr.active, o_stall && !r_s1_vld, "transaction during clear")
    `TBP_ASSERT_NEXT(a_s1_hold, r_s1_vld && !s1_adv, r_s1_vld && $stable(r_s1), "stage 1 lost")
    `TBP_ASSERT_NEXT(a_tally_mono, s1_adv, r_tally >= $past(r_tally), "tally decreased")
    `TBP_ASSERT_NEXT(a_hist_shift, s1_adv, r_history[0] == $past(r_s1.taken), "history not shifted")

endmodule
